### hw/rtl/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg: shared types and constants for the bisection cubic root block
// Fixed-point formats, register map, status codes and item payloads.
// ----------------------------------------------------------------------------
package bcr_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS   = 24;  // fraction bits of the evaluation format
  localparam int VALUE_WIDTH = 48;  // saturating evaluation width
  localparam int IN_W        = 32;  // Q8.24 interval ends and roots
  localparam int COEF_W      = 32;  // Q8.24 coefficients
  localparam int TOL_W       = 47;
  localparam int LIMIT_W     = 6;
  localparam int STEPS_W     = 6;

  // Split of the accumulator into two partial products on one multiplier
  localparam int LO_W   = FRAC_BITS;
  localparam int HI_W   = VALUE_WIDTH - FRAC_BITS;
  localparam int MA_W   = ((LO_W > HI_W) ? LO_W : HI_W) + 1;
  localparam int PROD_W = MA_W + IN_W;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Register port
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;
  localparam int IDX_LSB = 3;
  localparam int IDX_W   = ADDR_W - IDX_LSB;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_CUBIC    = 3'd0,
    REG_COEF_SQUARE   = 3'd1,
    REG_COEF_LINEAR   = 3'd2,
    REG_COEF_CONSTANT = 3'd3,
    REG_TOLERANCE     = 3'd4,
    REG_ITER_LIMIT    = 3'd5
  } bcr_reg_e;

  localparam logic signed [COEF_W-1:0] RST_COEF_CUBIC    = 32'sd50331648;
  localparam logic signed [COEF_W-1:0] RST_COEF_SQUARE   = -32'sd83886080;
  localparam logic signed [COEF_W-1:0] RST_COEF_LINEAR   = 32'sd50331648;
  localparam logic signed [COEF_W-1:0] RST_COEF_CONSTANT = -32'sd100663296;
  localparam logic [TOL_W-1:0]         RST_TOLERANCE     = 47'd168;
  localparam logic [LIMIT_W-1:0]       RST_ITER_LIMIT    = 6'd63;

  typedef enum logic [1:0] {
    STATUS_CONVERGED = 2'd0,
    STATUS_NO_CHANGE = 2'd1,
    STATUS_LIMIT     = 2'd2
  } bcr_status_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_cubic;
    logic signed [COEF_W-1:0] coef_square;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_constant;
    logic [TOL_W-1:0]         tolerance;
    logic [LIMIT_W-1:0]       iteration_limit;
  } bcr_cfg_t;

  typedef struct packed {
    logic signed [IN_W-1:0] left_end;
    logic signed [IN_W-1:0] right_end;
  } bcr_in_t;

  typedef struct packed {
    logic signed [IN_W-1:0]        root;
    logic signed [VALUE_WIDTH-1:0] residual;
    logic [STEPS_W-1:0]            steps_taken;
    bcr_status_e                   status;
  } bcr_out_t;

endpackage

### hw/rtl/bcr_cfg.sv
// ----------------------------------------------------------------------------
// bcr_cfg: configuration registers
// APB-style register file for the coefficients, tolerance and step limit.
// ----------------------------------------------------------------------------
module bcr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcr_pkg::DATA_W-1:0]   pwdata,
  output logic [bcr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bcr_pkg::bcr_cfg_t            cfg_o
);

  bcr_pkg::bcr_cfg_t cfg_q;
  bcr_pkg::bcr_reg_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = bcr_pkg::bcr_reg_e'(paddr[bcr_pkg::ADDR_W-1:bcr_pkg::IDX_LSB]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_cubic      <= bcr_pkg::RST_COEF_CUBIC;
      cfg_q.coef_square     <= bcr_pkg::RST_COEF_SQUARE;
      cfg_q.coef_linear     <= bcr_pkg::RST_COEF_LINEAR;
      cfg_q.coef_constant   <= bcr_pkg::RST_COEF_CONSTANT;
      cfg_q.tolerance       <= bcr_pkg::RST_TOLERANCE;
      cfg_q.iteration_limit <= bcr_pkg::RST_ITER_LIMIT;
    end else if (wr_en) begin
      unique case (idx)
        bcr_pkg::REG_COEF_CUBIC:    cfg_q.coef_cubic    <= pwdata[bcr_pkg::COEF_W-1:0];
        bcr_pkg::REG_COEF_SQUARE:   cfg_q.coef_square   <= pwdata[bcr_pkg::COEF_W-1:0];
        bcr_pkg::REG_COEF_LINEAR:   cfg_q.coef_linear   <= pwdata[bcr_pkg::COEF_W-1:0];
        bcr_pkg::REG_COEF_CONSTANT: cfg_q.coef_constant <= pwdata[bcr_pkg::COEF_W-1:0];
        bcr_pkg::REG_TOLERANCE:     cfg_q.tolerance     <= pwdata[bcr_pkg::TOL_W-1:0];
        bcr_pkg::REG_ITER_LIMIT:    cfg_q.iteration_limit <= pwdata[bcr_pkg::LIMIT_W-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bcr_pkg::REG_COEF_CUBIC:    prdata = bcr_pkg::DATA_W'($unsigned(cfg_q.coef_cubic));
      bcr_pkg::REG_COEF_SQUARE:   prdata = bcr_pkg::DATA_W'($unsigned(cfg_q.coef_square));
      bcr_pkg::REG_COEF_LINEAR:   prdata = bcr_pkg::DATA_W'($unsigned(cfg_q.coef_linear));
      bcr_pkg::REG_COEF_CONSTANT: prdata = bcr_pkg::DATA_W'($unsigned(cfg_q.coef_constant));
      bcr_pkg::REG_TOLERANCE:     prdata = bcr_pkg::DATA_W'(cfg_q.tolerance);
      bcr_pkg::REG_ITER_LIMIT:    prdata = bcr_pkg::DATA_W'(cfg_q.iteration_limit);
      default:                    prdata = '0;
    endcase
  end

endmodule

### hw/rtl/bcr_horner.sv
// ----------------------------------------------------------------------------
// bcr_horner: iterative cubic evaluator
// Horner's rule on one shared signed multiplier, with saturation.
// ----------------------------------------------------------------------------
module bcr_horner (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [bcr_pkg::IN_W-1:0]           x_i,
  input  bcr_pkg::bcr_cfg_t                         cfg_i,
  output logic                                      done_o,
  output logic signed [bcr_pkg::VALUE_WIDTH-1:0]    value_o
);

  localparam int VW = bcr_pkg::VALUE_WIDTH;
  localparam int F  = bcr_pkg::FRAC_BITS;
  localparam int PW = bcr_pkg::PROD_W;

  typedef enum logic [4:0] {
    H_IDLE    = 5'b00001,
    H_MUL_LO  = 5'b00010,
    H_MUL_HI  = 5'b00100,
    H_COMBINE = 5'b01000,
    H_ADD     = 5'b10000
  } h_state_e;

  h_state_e state_q, state_d;
  logic [1:0] term_q, term_d;
  logic       done_q, done_d;

  logic signed [bcr_pkg::IN_W-1:0] x_q;
  logic signed [VW-1:0]            acc_q;
  logic signed [PW-1:0]            p_lo_q, p_hi_q;

  logic signed [bcr_pkg::MA_W-1:0] op_a;
  logic signed [PW-1:0]            prod;
  logic signed [PW:0]              qf;
  logic                            rnd_up;
  logic signed [VW-1:0]            trunc_sat;
  logic signed [bcr_pkg::COEF_W-1:0] coef;
  logic signed [VW:0]              sum;
  logic signed [VW-1:0]            sum_sat;

  // Shared multiplier: low half is unsigned, high half carries the sign
  always_comb begin
    if (state_q == H_MUL_HI) begin
      op_a = bcr_pkg::MA_W'($signed(acc_q[VW-1:F]));
    end else begin
      op_a = bcr_pkg::MA_W'($unsigned(acc_q[F-1:0]));
    end
    prod = PW'(op_a) * PW'(x_q);
  end

  // floor(acc*x / 2^F) plus one when the product is negative and inexact
  always_comb begin
    rnd_up = (acc_q[VW-1] ^ x_q[bcr_pkg::IN_W-1]) & (|p_lo_q[F-1:0]);
    qf     = (PW+1)'(p_hi_q) + (PW+1)'(p_lo_q >>> F) + (PW+1)'(rnd_up);
    if (qf > (PW+1)'(bcr_pkg::VAL_MAX)) begin
      trunc_sat = bcr_pkg::VAL_MAX;
    end else if (qf < (PW+1)'(bcr_pkg::VAL_MIN)) begin
      trunc_sat = bcr_pkg::VAL_MIN;
    end else begin
      trunc_sat = qf[VW-1:0];
    end
  end

  always_comb begin
    case (term_q)
      2'd0:    coef = cfg_i.coef_square;
      2'd1:    coef = cfg_i.coef_linear;
      default: coef = cfg_i.coef_constant;
    endcase
    sum = (VW+1)'(acc_q) + (VW+1)'(coef);
    if (sum > (VW+1)'(bcr_pkg::VAL_MAX)) begin
      sum_sat = bcr_pkg::VAL_MAX;
    end else if (sum < (VW+1)'(bcr_pkg::VAL_MIN)) begin
      sum_sat = bcr_pkg::VAL_MIN;
    end else begin
      sum_sat = sum[VW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    done_d  = 1'b0;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          state_d = H_MUL_LO;
          term_d  = 2'd0;
        end
      end
      H_MUL_LO:  state_d = H_MUL_HI;
      H_MUL_HI:  state_d = H_COMBINE;
      H_COMBINE: state_d = H_ADD;
      H_ADD: begin
        if (term_q == 2'd2) begin
          state_d = H_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = H_MUL_LO;
          term_d  = term_q + 2'd1;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      term_q  <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          x_q   <= x_i;
          acc_q <= VW'(cfg_i.coef_cubic);
        end
      end
      H_MUL_LO:  p_lo_q <= prod;
      H_MUL_HI:  p_hi_q <= prod;
      H_COMBINE: acc_q  <= trunc_sat;
      H_ADD:     acc_q  <= sum_sat;
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign value_o = acc_q;

endmodule

### hw/rtl/bisection_cubic_root.sv
// ----------------------------------------------------------------------------
// bisection_cubic_root: bisection root finder for a programmable cubic
// Bisects a Q8.24 interval on f(x) = c3 x^3 + c2 x^2 + c1 x + c0.
// ----------------------------------------------------------------------------
// An item carries the interval ends [left_end, right_end] in signed Q8.24 and
// yields exactly one result item: the last midpoint, f at that midpoint in
// saturated Q24.24 (both zero when there is no sign change), the step count
// and a status (converged, no sign change, step limit). Every evaluation of
// f runs Horner's rule on a single shared 25x32 signed multiplier: each of
// the three terms takes two partial products, a combine/truncate step and a
// saturating add. An item takes two end-point evaluations, then a midpoint
// update and one evaluation per bisection step; an interval without a sign
// change finishes after the two end-point evaluations. in_stall_o is high
// while an item is in work. The result sits in an output register, so the
// next item is taken while a result is still waiting on out_stall_i.
// Registers (64-bit APB, byte address 8*index) must only be written while
// the block is idle.
// ----------------------------------------------------------------------------
module bisection_cubic_root (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bcr_pkg::bcr_in_t             in_data_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bcr_pkg::bcr_out_t            out_data_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bcr_pkg::DATA_W-1:0]   pwdata,
  output logic [bcr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int VW = bcr_pkg::VALUE_WIDTH;
  localparam int XW = bcr_pkg::IN_W;
  localparam int SW = bcr_pkg::STEPS_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL_A = 7'b0000010,
    ST_EVAL_B = 7'b0000100,
    ST_MID    = 7'b0001000,
    ST_EVAL_C = 7'b0010000,
    ST_OUT    = 7'b0100000,
    ST_SPARE  = 7'b1000000   // never entered
  } state_e;

  state_e state_q, state_d;

  bcr_pkg::bcr_cfg_t cfg;

  // evaluator handshake
  logic                    h_start;
  logic signed [XW-1:0]    h_x;
  logic                    h_done;
  logic signed [VW-1:0]    h_val;

  // working registers
  logic signed [XW-1:0]    a_q, b_q, c_q;
  logic signed [VW-1:0]    fa_q, fc_q;
  logic [SW-1:0]           steps_q;
  bcr_pkg::bcr_status_e    status_q;

  logic                    out_valid_q;
  bcr_pkg::bcr_out_t       out_q;

  logic                    in_acc;
  logic                    out_load;
  logic signed [XW:0]      mid_sum;
  logic signed [XW-1:0]    mid;
  logic                    opp_ab, opp_ac;
  logic [VW-1:0]           fc_mag;
  logic                    conv;
  logic [SW:0]             steps_nx;
  logic                    at_limit;

  bcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcr_horner u_horner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (h_start),
    .x_i     (h_x),
    .cfg_i   (cfg),
    .done_o  (h_done),
    .value_o (h_val)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // midpoint: arithmetic shift of the 33-bit sum
  assign mid_sum = (XW+1)'(a_q) + (XW+1)'(b_q);
  assign mid     = mid_sum[XW:1];

  // strictly opposite signs; zero matches neither side
  assign opp_ab = (fa_q[VW-1] & ~h_val[VW-1] & (|h_val)) |
                  (~fa_q[VW-1] & (|fa_q) & h_val[VW-1]);
  assign opp_ac = opp_ab;  // same test, fa against the midpoint value

  assign fc_mag   = h_val[VW-1] ? (~h_val + VW'(1)) : h_val;
  assign conv     = fc_mag < VW'(cfg.tolerance);
  assign steps_nx = (SW+1)'(steps_q) + (SW+1)'(1);
  // a zero limit still allows one step, since steps_nx is at least one
  assign at_limit = steps_nx >= (SW+1)'(cfg.iteration_limit);

  assign out_load = (state_q == ST_OUT) & (~out_valid_q | ~out_stall_i);

  // evaluator start and operand
  always_comb begin
    h_start = 1'b0;
    h_x     = in_data_i.left_end;
    unique case (state_q)
      ST_IDLE: h_start = in_acc;
      ST_EVAL_A: begin
        h_start = h_done;
        h_x     = b_q;
      end
      ST_MID: begin
        h_start = 1'b1;
        h_x     = mid;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_EVAL_A;
      ST_EVAL_A: if (h_done) state_d = ST_EVAL_B;
      ST_EVAL_B: if (h_done) state_d = opp_ab ? ST_MID : ST_OUT;
      ST_MID:    state_d = ST_EVAL_C;
      ST_EVAL_C: if (h_done) state_d = (conv | at_limit) ? ST_OUT : ST_MID;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          a_q     <= in_data_i.left_end;
          b_q     <= in_data_i.right_end;
          steps_q <= '0;
        end
      end
      ST_EVAL_A: begin
        if (h_done) fa_q <= h_val;
      end
      ST_EVAL_B: begin
        if (h_done && !opp_ab) begin
          c_q      <= '0;
          fc_q     <= '0;
          status_q <= bcr_pkg::STATUS_NO_CHANGE;
        end
      end
      ST_MID: c_q <= mid;
      ST_EVAL_C: begin
        if (h_done) begin
          fc_q    <= h_val;
          steps_q <= steps_nx[SW-1:0];
          if (opp_ac) begin
            b_q <= c_q;
          end else begin
            a_q  <= c_q;
            fa_q <= h_val;
          end
          status_q <= conv ? bcr_pkg::STATUS_CONVERGED : bcr_pkg::STATUS_LIMIT;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.root        <= c_q;
      out_q.residual    <= fc_q;
      out_q.steps_taken <= steps_q;
      out_q.status      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/bisection_cubic_root_test.sv
// ----------------------------------------------------------------------------
// bisection_cubic_root_test: self-checking bench for the bisection root finder
// Drives intervals through the valid/stall input channel, programs the cubic
// over APB between phases, and checks every result against a bit-exact
// fixed-point bisection predictor. Random input gaps and random result stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bisection_cubic_root_test;
  import bcr_pkg::*;

  // Hang guard limit, with room for the longest items (limit 63) and for
  // idle gaps and result stalls on top.
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int unsigned RANDOM_PHASES = 16;
  localparam int unsigned PHASE_ITEMS   = 96;
  localparam int unsigned SETTLE_CYCLES = 32;   // result is registered
  localparam int unsigned MAX_REPORTS   = 40;

  // Q8.24 operands used by the directed part
  localparam int Q_ONE   = 1 << FRAC_BITS;
  localparam int Q_THREE = 3 * Q_ONE;
  localparam int Q_FOUR  = 4 * Q_ONE;
  localparam int Q_MAX   = 32'sh7FFF_FFFF;
  localparam int Q_MIN   = 32'sh8000_0000;

  // Register slots past the map; writes there must be dropped
  localparam logic [IDX_W-1:0] UNMAPPED_LOW  = 3'd6;
  localparam logic [IDX_W-1:0] UNMAPPED_HIGH = 3'd7;

  typedef struct {
    bcr_in_t     span;
    bcr_out_t    want;
    int unsigned seq;
  } pending_root_t;

  // --------------------------------------------------------------------------
  // Predictor and result store. Holds its own copy of the register file and
  // replays the bisection in 64-bit integers, saturating like the datapath.
  // --------------------------------------------------------------------------
  class root_predictor;
    bcr_cfg_t        cfg;
    pending_root_t   expected_roots[$];
    int unsigned     accepted = 0;
    int unsigned     checked = 0;
    int unsigned     errors = 0;
    int unsigned     converged_cnt = 0;
    int unsigned     no_change_cnt = 0;
    int unsigned     limit_cnt = 0;
    longint          sat_hi = longint'(VAL_MAX);
    longint          sat_lo = longint'(VAL_MIN);

    function new();
      cfg.coef_cubic      = RST_COEF_CUBIC;
      cfg.coef_square     = RST_COEF_SQUARE;
      cfg.coef_linear     = RST_COEF_LINEAR;
      cfg.coef_constant   = RST_COEF_CONSTANT;
      cfg.tolerance       = RST_TOLERANCE;
      cfg.iteration_limit = RST_ITER_LIMIT;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_COEF_CUBIC:    cfg.coef_cubic      = value[COEF_W-1:0];
        REG_COEF_SQUARE:   cfg.coef_square     = value[COEF_W-1:0];
        REG_COEF_LINEAR:   cfg.coef_linear     = value[COEF_W-1:0];
        REG_COEF_CONSTANT: cfg.coef_constant   = value[COEF_W-1:0];
        REG_TOLERANCE:     cfg.tolerance       = value[TOL_W-1:0];
        REG_ITER_LIMIT:    cfg.iteration_limit = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // acc*x / 2^FRAC_BITS, truncated toward zero, saturated to VALUE_WIDTH
    function longint scaled_product(longint acc, longint x);
      logic [79:0] prod;
      longint      mag_a, mag_x, cap;
      bit          neg;
      neg   = (acc < 0) != (x < 0);
      mag_a = (acc < 0) ? -acc : acc;
      mag_x = (x < 0) ? -x : x;
      cap   = -sat_lo;
      prod  = 80'(mag_a) * 80'(mag_x);
      prod  = prod >> FRAC_BITS;
      if (prod >= 80'(cap)) return neg ? sat_lo : sat_hi;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint clamped_sum(longint acc, longint k);
      longint s;
      s = acc + k;
      if (s > sat_hi) return sat_hi;
      if (s < sat_lo) return sat_lo;
      return s;
    endfunction

    // Horner: ((c3*x + c2)*x + c1)*x + c0
    function longint cubic_at(longint x);
      longint acc;
      acc = longint'($signed(cfg.coef_cubic));
      acc = clamped_sum(scaled_product(acc, x), longint'($signed(cfg.coef_square)));
      acc = clamped_sum(scaled_product(acc, x), longint'($signed(cfg.coef_linear)));
      acc = clamped_sum(scaled_product(acc, x), longint'($signed(cfg.coef_constant)));
      return acc;
    endfunction

    function bit opposite_signs(longint p, longint q);
      return (p < 0 && q > 0) || (p > 0 && q < 0);
    endfunction

    function bcr_out_t bisect(bcr_in_t span);
      longint   lo, hi, mid, f_lo, f_hi, f_mid, mag;
      int       steps;
      bit       done;
      bcr_out_t r;
      lo   = longint'($signed(span.left_end));
      hi   = longint'($signed(span.right_end));
      f_lo = cubic_at(lo);
      f_hi = cubic_at(hi);
      r    = '0;
      r.status = STATUS_NO_CHANGE;
      if (!opposite_signs(f_lo, f_hi)) return r;
      steps = 0;
      done  = 0;
      mid   = 0;
      f_mid = 0;
      while (!done) begin
        mid   = (lo + hi) >>> 1;
        f_mid = cubic_at(mid);
        if (opposite_signs(f_lo, f_mid)) begin
          hi = mid;
        end else begin
          lo   = mid;
          f_lo = f_mid;
        end
        steps++;
        mag = (f_mid < 0) ? -f_mid : f_mid;
        // convergence wins over the limit on the same step
        if (mag < longint'(cfg.tolerance)) begin
          r.status = STATUS_CONVERGED;
          done = 1;
        end else if (steps >= int'(cfg.iteration_limit)) begin
          r.status = STATUS_LIMIT;
          done = 1;
        end
      end
      r.root        = mid[IN_W-1:0];
      r.residual    = f_mid[VALUE_WIDTH-1:0];
      r.steps_taken = steps[STEPS_W-1:0];
      return r;
    endfunction

    function void note_interval(bcr_in_t span);
      pending_root_t e;
      e.span = span;
      e.want = bisect(span);
      e.seq  = accepted;
      accepted++;
      case (e.want.status)
        STATUS_CONVERGED: converged_cnt++;
        STATUS_NO_CHANGE: no_change_cnt++;
        default:          limit_cnt++;
      endcase
      expected_roots.push_back(e);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_root(bcr_out_t got);
      pending_root_t head;
      if (expected_roots.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, root %h", got.root));
        return;
      end
      head = expected_roots.pop_front();
      checked++;
      if (got.root !== head.want.root)
        report_mismatch($sformatf("item %0d [%h,%h] root %h, want %h", head.seq,
          head.span.left_end, head.span.right_end, got.root, head.want.root));
      if (got.residual !== head.want.residual)
        report_mismatch($sformatf("item %0d [%h,%h] residual %h, want %h", head.seq,
          head.span.left_end, head.span.right_end, got.residual, head.want.residual));
      if (got.steps_taken !== head.want.steps_taken)
        report_mismatch($sformatf("item %0d [%h,%h] steps %0d, want %0d", head.seq,
          head.span.left_end, head.span.right_end, got.steps_taken,
          head.want.steps_taken));
      if (got.status !== head.want.status)
        report_mismatch($sformatf("item %0d [%h,%h] status %0d, want %0d", head.seq,
          head.span.left_end, head.span.right_end, got.status, head.want.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  bcr_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  bcr_out_t          out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  root_predictor     book = new();
  bit                idle_on = 1'b1;     // random gaps/stalls allowed
  int                stall_left = 0;
  bit                stall_burst = 1'b0;
  int unsigned       cycle_count = 0;
  int unsigned       settings_used = 1;  // reset settings count as one

  bisection_cubic_root uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Result side: stall comes in random bursts, mixed with open runs
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left  = $urandom_range(1, 12);
      stall_burst = idle_on && ($urandom_range(0, 2) == 0);
    end
    stall_left--;
    out_stall_i <= stall_burst && idle_on;
  end

  // Every accepted result goes to the store, oldest expectation first
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      book.check_root(out_data_o);
    end
  end

  // Hang guard
  initial begin
    do begin
      @(posedge clk_i);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
             book.expected_roots.size());
    $display("bisection_cubic_root regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes sampled on rising
  // --------------------------------------------------------------------------

  // Optional idle burst, then hold the item until the block takes it
  task automatic issue_interval(int a, int b);
    bcr_in_t span;
    int      gap;
    span.left_end  = a;
    span.right_end = b;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= span;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    book.note_interval(span);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (book.expected_roots.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup, then access until pready
  task automatic write_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {IDX_LSB{1'b0}}};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    book.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New cubic and stopping rule; only once the block has gone quiet
  task automatic program_cubic(int c3, int c2, int c1, int c0,
                               logic [TOL_W-1:0] tol, logic [LIMIT_W-1:0] limit);
    wait_for_results();
    write_register(REG_COEF_CUBIC, DATA_W'(c3));
    write_register(REG_COEF_SQUARE, DATA_W'(c2));
    write_register(REG_COEF_LINEAR, DATA_W'(c1));
    write_register(REG_COEF_CONSTANT, DATA_W'(c0));
    write_register(REG_TOLERANCE, DATA_W'(tol));
    write_register(REG_ITER_LIMIT, DATA_W'(limit));
    settings_used++;
  endtask

  // Mostly modest coefficients so roots land inside the Q8.24 range
  function automatic int rand_coef();
    case ($urandom_range(0, 9))
      7, 8:    return int'($urandom);
      9:       return ($urandom_range(0, 1) == 1) ? Q_MAX : Q_MIN;
      default: return int'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      phase, n, style, reach;
    int               a, b, t;
    logic [TOL_W-1:0] tol;
    logic [LIMIT_W-1:0] limit;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Reset settings: 3x^3 - 5x^2 + 3x - 6, one real root near 1.75
    issue_interval(0, Q_FOUR);                  // plain bracket
    issue_interval(Q_FOUR, 0);                  // reversed ends
    issue_interval(Q_ONE, Q_ONE);               // degenerate interval
    issue_interval(0, Q_ONE);                   // both ends negative
    issue_interval(Q_MIN, Q_MAX);               // widest span
    issue_interval(Q_MAX, Q_MIN);
    issue_interval(Q_MIN, Q_MIN);
    issue_interval(0, 0);
    issue_interval(32'sh5555_5555, 32'shAAAA_AAAA);

    // f(x) = x, zero tolerance, limit zero behaves as one step
    program_cubic(0, 0, Q_ONE, 0, '0, '0);
    write_register(UNMAPPED_LOW, {$urandom, $urandom});
    write_register(UNMAPPED_HIGH, {$urandom, $urandom});
    issue_interval(-Q_ONE, Q_ONE);              // midpoint is an exact zero
    issue_interval(0, Q_ONE);                   // one end is an exact root
    issue_interval(-Q_ONE, Q_THREE);

    // Converges exactly on the last allowed step: status must say converged
    program_cubic(0, 0, Q_ONE, 0, TOL_W'(Q_ONE), LIMIT_W'(2));
    issue_interval(-Q_ONE, Q_THREE);
    issue_interval(Q_THREE, -Q_ONE);

    // Zero residual never counts as converged: runs to the full limit
    program_cubic(0, 0, Q_ONE, 0, '0, LIMIT_W'(63));
    issue_interval(-Q_ONE, Q_ONE);

    // Saturation at both rails, widest tolerance
    program_cubic(Q_MAX, Q_MAX, Q_MAX, Q_MAX, '1, LIMIT_W'(1));
    issue_interval(Q_MIN, Q_MAX);
    issue_interval(Q_MAX, Q_MIN);
    program_cubic(Q_MIN, Q_MIN, Q_MIN, Q_MIN, '1, LIMIT_W'(63));
    issue_interval(Q_MIN, Q_MAX);
    issue_interval(-Q_ONE, Q_ONE);

    // Random phases; two of them run with the full 63-step limit
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       tol = '0;
        1:       tol = TOL_W'({$urandom, $urandom});
        2, 3, 4: tol = TOL_W'($urandom_range(0, 4096));
        default: tol = TOL_W'($urandom_range(4096, 1 << FRAC_BITS));
      endcase
      limit = (phase % 6 == 4) ? LIMIT_W'(63) : LIMIT_W'($urandom_range(0, 24));
      program_cubic(rand_coef(), rand_coef(), rand_coef(), rand_coef(), tol, limit);
      // final phase runs flat out on both channels
      idle_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // now and then the sender holds until the pipe is empty
        if ((phase == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 63) == 0)
          wait_for_results();
        style = $urandom_range(0, 19);
        if (style < 3) begin
          // raw bits, exercises every input bit
          a = int'($urandom);
          b = int'($urandom);
        end else if (style < 17) begin
          // straddles zero, so most cubics change sign inside
          case ($urandom_range(0, 2))
            0:       reach = 32'h0800_0000;
            1:       reach = 32'h2000_0000;
            default: reach = 32'h7FFF_FFFF;
          endcase
          a = -int'($urandom_range(0, reach));
          b = int'($urandom_range(0, reach));
          if ($urandom_range(0, 1) == 1) begin
            t = a;
            a = b;
            b = t;
          end
        end else begin
          // narrow interval, at most 0.25 wide, starting in [-16, 16)
          a = int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
          b = a + int'($urandom_range(1, 32'h0040_0000));
        end
        issue_interval(a, b);
      end
    end

    wait_for_results();

    $display("covered %0d intervals under %0d register settings in %0d cycles",
             book.accepted, settings_used, cycle_count);
    $display("outcomes: %0d converged, %0d without sign change, %0d at step limit",
             book.converged_cnt, book.no_change_cnt, book.limit_cnt);
    if (book.errors == 0) begin
      $display("bisection_cubic_root regression: pass");
    end else begin
      $display("%0d mismatches", book.errors);
      $display("bisection_cubic_root regression: fail");
    end
    $finish;
  end

endmodule
